// File: sv/tmfs_pkg.sv
package tmfs_pkg;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [2:0] REG_DRIVE_DUTY  = 3'd0;
  localparam logic [2:0] REG_FIRST_BACK  = 3'd1;
  localparam logic [2:0] REG_SECOND_BACK = 3'd2;
  localparam logic [2:0] REG_SETTLE      = 3'd3;
  localparam logic [2:0] REG_PULL        = 3'd4;

  // Register reset values
  localparam logic [7:0]  DRIVE_DUTY_RST  = 8'd255;
  localparam logic [15:0] FIRST_BACK_RST  = 16'd1500;
  localparam logic [15:0] SECOND_BACK_RST = 16'd1000;
  localparam logic [15:0] SETTLE_RST      = 16'd3000;
  localparam logic [15:0] PULL_RST        = 16'd2000;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_GO      = 2'd0,
    CMD_RESET   = 2'd1,
    CMD_STOP    = 2'd2,
    CMD_INVALID = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REPLY_NONE    = 3'd0,
    REPLY_GO      = 3'd1,
    REPLY_RESET   = 3'd2,
    REPLY_STOP    = 3'd3,
    REPLY_INVALID = 3'd4
  } reply_e;

  typedef enum logic [3:0] {
    STEP_IDLE           = 4'd0,
    STEP_SLAB1_START    = 4'd1,
    STEP_SLAB1_WAIT     = 4'd2,
    STEP_BACKOFF1_START = 4'd3,
    STEP_BACKOFF1_WAIT  = 4'd4,
    STEP_PULL_START     = 4'd5,
    STEP_PULL_WAIT      = 4'd6,
    STEP_SLAB2_START    = 4'd7,
    STEP_SLAB2_WAIT     = 4'd8,
    STEP_BACKOFF2_START = 4'd9,
    STEP_BACKOFF2_WAIT  = 4'd10,
    STEP_SETTLE         = 4'd11,
    STEP_PULL_CW        = 4'd12,
    STEP_SLAB3_START    = 4'd13,
    STEP_SLAB3_WAIT     = 4'd14,
    STEP_DONE           = 4'd15
  } step_e;

  typedef struct packed {
    logic [7:0]  drive_duty;
    logic [15:0] first_backoff_ms;
    logic [15:0] second_backoff_ms;
    logic [15:0] settle_ms;
    logic [15:0] pull_ms;
  } cfg_t;

  // One H-bridge: A/B levels and PWM duty, all zero means off
  typedef struct packed {
    logic       in_a;
    logic       in_b;
    logic [7:0] duty;
  } drive_t;

  typedef struct packed {
    logic func;
    cmd_e command;
    logic slab_switch;
    logic limit_switch;
  } item_t;

  typedef struct packed {
    drive_t pull;
    drive_t slab;
    step_e  step_number;
    logic   busy_res;
    reply_e reply;
  } result_t;

endpackage

// File: sv/two_motor_feed_sequencer.sv
// Two-motor feed sequencer: steps a pull motor and a slab motor through a
// fixed fifteen-step feed sequence.
// Input stream (s_axis): one transaction per command or per one-millisecond
// tick; tuser tells which, tdata carries the command code and switch levels.
// Output stream (m_axis): exactly one transaction per input transaction,
// giving both bridge drives, the step, the busy flag and the command reply.
// Configuration: APB port with drive duty and the four step times at byte
// addresses 0, 4, 8, 12 and 16; write them only while the stream is idle.
// A transaction passes through the input register and then the result
// register on its way to m_axis.
// Throughput: one transaction per cycle while m_axis_tready is high; the
// step update is a single pass of next-step logic with one 16-bit compare
// against a step time. A stall on m_axis_tready holds the result register;
// the input register still takes one more transaction, then s_axis_tready
// drops until the result is taken.
// Reset: step 0, not running, counter cleared, both motors off, registers
// back to their default values, both streams empty.
module two_motor_feed_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [1:0] command, [2] slab_switch,
                                     // [3] limit_switch, [7:4] zero
  input  logic        s_axis_tuser,  // [0] func
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [0] pull_in_a, [1] pull_in_b,
                                     // [9:2] pull_duty, [10] slab_in_a,
                                     // [11] slab_in_b, [19:12] slab_duty,
                                     // [23:20] step_number, [24] busy_res,
                                     // [27:25] reply, [31:28] zero
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tmfs_pkg::cfg_t    cfg;
  tmfs_pkg::item_t   item_q;
  tmfs_pkg::result_t result;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;

  tmfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Result register is free or being emptied this cycle
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= '{func: s_axis_tuser,
                  command: tmfs_pkg::cmd_e'(s_axis_tdata[1:0]),
                  slab_switch: s_axis_tdata[2],
                  limit_switch: s_axis_tdata[3]};
    end
  end

  tmfs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .load_i   (advance && in_valid_q),
    .item_i   (item_q),
    .result_o (result)
  );

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, result.reply, result.busy_res, result.step_number,
                          result.slab.duty, result.slab.in_b, result.slab.in_a,
                          result.pull.duty, result.pull.in_b, result.pull.in_a};

  // Input side only stalls behind a held result
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

  // Go always lands on the first step with the sequence running
  a_go_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result.reply == tmfs_pkg::REPLY_GO) |->
    (result.step_number == tmfs_pkg::STEP_SLAB1_START && result.busy_res))
    else $error("go reply without sequence start");

  // Reset and stop leave both motors off
  a_motors_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (result.reply == tmfs_pkg::REPLY_RESET ||
                       result.reply == tmfs_pkg::REPLY_STOP)) |->
    (result.pull == '0 && result.slab == '0))
    else $error("motor left driven after reset or stop");

  // A stalled result holds its value
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

// File: sv/tmfs_regs.sv
module tmfs_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output tmfs_pkg::cfg_t      cfg_o
);

  tmfs_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_duty        <= tmfs_pkg::DRIVE_DUTY_RST;
      cfg_q.first_backoff_ms  <= tmfs_pkg::FIRST_BACK_RST;
      cfg_q.second_backoff_ms <= tmfs_pkg::SECOND_BACK_RST;
      cfg_q.settle_ms         <= tmfs_pkg::SETTLE_RST;
      cfg_q.pull_ms           <= tmfs_pkg::PULL_RST;
    end else if (wr_en) begin
      case (reg_idx)
        tmfs_pkg::REG_DRIVE_DUTY:  cfg_q.drive_duty        <= pwdata[7:0];
        tmfs_pkg::REG_FIRST_BACK:  cfg_q.first_backoff_ms  <= pwdata[15:0];
        tmfs_pkg::REG_SECOND_BACK: cfg_q.second_backoff_ms <= pwdata[15:0];
        tmfs_pkg::REG_SETTLE:      cfg_q.settle_ms         <= pwdata[15:0];
        tmfs_pkg::REG_PULL:        cfg_q.pull_ms           <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      tmfs_pkg::REG_DRIVE_DUTY:  prdata = {24'd0, cfg_q.drive_duty};
      tmfs_pkg::REG_FIRST_BACK:  prdata = {16'd0, cfg_q.first_backoff_ms};
      tmfs_pkg::REG_SECOND_BACK: prdata = {16'd0, cfg_q.second_backoff_ms};
      tmfs_pkg::REG_SETTLE:      prdata = {16'd0, cfg_q.settle_ms};
      tmfs_pkg::REG_PULL:        prdata = {16'd0, cfg_q.pull_ms};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// File: sv/tmfs_core.sv
module tmfs_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmfs_pkg::cfg_t      cfg_i,
  input  logic                load_i,
  input  tmfs_pkg::item_t     item_i,
  output tmfs_pkg::result_t   result_o
);

  tmfs_pkg::step_e   step_q, step_d;
  logic              running_q, running_d;
  logic [15:0]       elapsed_q, elapsed_d, elapsed_inc;
  tmfs_pkg::drive_t  pull_q, pull_d, slab_q, slab_d;
  tmfs_pkg::drive_t  drive_cw, drive_ccw;
  tmfs_pkg::reply_e  reply_d;
  tmfs_pkg::result_t result_q;

  assign drive_cw  = '{in_a: 1'b1, in_b: 1'b0, duty: cfg_i.drive_duty};
  assign drive_ccw = '{in_a: 1'b0, in_b: 1'b1, duty: cfg_i.drive_duty};

  // Saturating millisecond count for this tick
  assign elapsed_inc = (elapsed_q == tmfs_pkg::ELAPSED_MAX) ? elapsed_q
                                                            : elapsed_q + 16'd1;

  // Next sequence state for the item at the input register
  always_comb begin
    step_d    = step_q;
    running_d = running_q;
    elapsed_d = elapsed_q;
    pull_d    = pull_q;
    slab_d    = slab_q;
    reply_d   = tmfs_pkg::REPLY_NONE;
    if (item_i.func) begin
      case (item_i.command)
        tmfs_pkg::CMD_GO: begin
          reply_d   = tmfs_pkg::REPLY_GO;
          step_d    = tmfs_pkg::STEP_SLAB1_START;
          running_d = 1'b1;
        end
        tmfs_pkg::CMD_RESET: begin
          reply_d   = tmfs_pkg::REPLY_RESET;
          step_d    = tmfs_pkg::STEP_IDLE;
          running_d = 1'b0;
          elapsed_d = 16'd0;
          pull_d    = '0;
          slab_d    = '0;
        end
        tmfs_pkg::CMD_STOP: begin
          reply_d = tmfs_pkg::REPLY_STOP;
          pull_d  = '0;
          slab_d  = '0;
        end
        default: begin
          reply_d   = tmfs_pkg::REPLY_INVALID;
          step_d    = tmfs_pkg::STEP_IDLE;
          running_d = 1'b0;
        end
      endcase
    end else begin
      elapsed_d = elapsed_inc;
      if (running_q) begin
        case (step_q)
          tmfs_pkg::STEP_SLAB1_START: begin
            slab_d = drive_ccw;
            step_d = tmfs_pkg::STEP_SLAB1_WAIT;
          end
          tmfs_pkg::STEP_SLAB1_WAIT: begin
            if (!item_i.slab_switch) begin
              slab_d = '0;
              step_d = tmfs_pkg::STEP_BACKOFF1_START;
            end
          end
          tmfs_pkg::STEP_BACKOFF1_START: begin
            slab_d    = drive_cw;
            elapsed_d = 16'd0;
            step_d    = tmfs_pkg::STEP_BACKOFF1_WAIT;
          end
          tmfs_pkg::STEP_BACKOFF1_WAIT: begin
            if (elapsed_inc >= cfg_i.first_backoff_ms) begin
              slab_d = '0;
              step_d = tmfs_pkg::STEP_PULL_START;
            end
          end
          tmfs_pkg::STEP_PULL_START: begin
            pull_d = drive_ccw;
            step_d = tmfs_pkg::STEP_PULL_WAIT;
          end
          tmfs_pkg::STEP_PULL_WAIT: begin
            if (item_i.limit_switch) begin
              pull_d = '0;
              step_d = tmfs_pkg::STEP_SLAB2_START;
            end
          end
          tmfs_pkg::STEP_SLAB2_START: begin
            slab_d = drive_ccw;
            step_d = tmfs_pkg::STEP_SLAB2_WAIT;
          end
          tmfs_pkg::STEP_SLAB2_WAIT: begin
            if (!item_i.slab_switch) begin
              slab_d = '0;
              step_d = tmfs_pkg::STEP_BACKOFF2_START;
            end
          end
          tmfs_pkg::STEP_BACKOFF2_START: begin
            slab_d    = drive_cw;
            elapsed_d = 16'd0;
            step_d    = tmfs_pkg::STEP_BACKOFF2_WAIT;
          end
          tmfs_pkg::STEP_BACKOFF2_WAIT: begin
            if (elapsed_inc >= cfg_i.second_backoff_ms) begin
              slab_d    = '0;
              elapsed_d = 16'd0;
              step_d    = tmfs_pkg::STEP_SETTLE;
            end
          end
          tmfs_pkg::STEP_SETTLE: begin
            if (elapsed_inc >= cfg_i.settle_ms) begin
              pull_d    = drive_cw;
              elapsed_d = 16'd0;
              step_d    = tmfs_pkg::STEP_PULL_CW;
            end
          end
          tmfs_pkg::STEP_PULL_CW: begin
            if (elapsed_inc >= cfg_i.pull_ms) begin
              pull_d = '0;
              step_d = tmfs_pkg::STEP_SLAB3_START;
            end
          end
          tmfs_pkg::STEP_SLAB3_START: begin
            slab_d = drive_ccw;
            step_d = tmfs_pkg::STEP_SLAB3_WAIT;
          end
          tmfs_pkg::STEP_SLAB3_WAIT: begin
            if (!item_i.slab_switch) begin
              slab_d = '0;
              step_d = tmfs_pkg::STEP_DONE;
            end
          end
          tmfs_pkg::STEP_DONE: begin
            running_d = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Commit the sequence state when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= tmfs_pkg::STEP_IDLE;
      running_q <= 1'b0;
      elapsed_q <= 16'd0;
      pull_q    <= '0;
      slab_q    <= '0;
    end else if (load_i) begin
      step_q    <= step_d;
      running_q <= running_d;
      elapsed_q <= elapsed_d;
      pull_q    <= pull_d;
      slab_q    <= slab_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= '{pull: pull_d, slab: slab_d, step_number: step_d,
                    busy_res: running_d, reply: reply_d};
    end
  end

  assign result_o = result_q;

endmodule

// File: verif/feed_sequencer_checker.sv
module feed_sequencer_checker
  import tmfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command and tick stream into the block
  input  logic        in_tvalid_i,
  input  logic        in_tready_i,
  input  logic [7:0]  in_tdata_i,   // [1:0] command, [2] slab_switch, [3] limit_switch
  input  logic        in_tuser_i,   // [0] func
  // Motor state stream out of the block
  input  logic        out_tvalid_i,
  input  logic        out_tready_i,
  input  logic [31:0] out_tdata_i,  // [1:0] pull a/b, [9:2] pull duty, [11:10] slab a/b,
                                    // [19:12] slab duty, [23:20] step, [24] busy,
                                    // [27:25] reply
  // Register writes
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          mismatch_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the registers and of the sequencer state
  cfg_t        cfg_q;
  step_e       step_q;
  logic        running_q;
  logic [15:0] elapsed_q;
  drive_t      pull_q;
  drive_t      slab_q;

  // Motor states predicted for transactions accepted but not yet seen at the output
  result_t     motor_state_q[$];

  // Bridge levels for one direction at the current duty
  function automatic drive_t drive_level(logic clockwise);
    drive_t d;
    d.in_a = clockwise;
    d.in_b = !clockwise;
    d.duty = cfg_q.drive_duty;
    return d;
  endfunction

  function automatic void clear_sequence();
    step_q = STEP_IDLE;
    running_q = 1'b0;
    elapsed_q = '0;
    pull_q = '0;
    slab_q = '0;
  endfunction

  // Advance the shadow sequencer by one transaction and return the motor state
  function automatic result_t predict_motors(item_t it);
    result_t res;
    logic pressed;
    pressed = !it.slab_switch;
    res.reply = REPLY_NONE;
    if (it.func) begin
      case (it.command)
        CMD_GO: begin
          step_q = STEP_SLAB1_START;
          running_q = 1'b1;
          res.reply = REPLY_GO;
        end
        CMD_RESET: begin
          clear_sequence();
          res.reply = REPLY_RESET;
        end
        CMD_STOP: begin
          pull_q = '0;
          slab_q = '0;
          res.reply = REPLY_STOP;
        end
        default: begin
          step_q = STEP_IDLE;
          running_q = 1'b0;
          res.reply = REPLY_INVALID;
        end
      endcase
    end else begin
      // Count the millisecond first, then let the timed steps compare
      if (elapsed_q != ELAPSED_MAX) elapsed_q = elapsed_q + 16'd1;
      if (running_q) begin
        case (step_q)
          STEP_SLAB1_START: begin
            slab_q = drive_level(1'b0);
            step_q = STEP_SLAB1_WAIT;
          end
          STEP_SLAB1_WAIT: if (pressed) begin
            slab_q = '0;
            step_q = STEP_BACKOFF1_START;
          end
          STEP_BACKOFF1_START: begin
            slab_q = drive_level(1'b1);
            elapsed_q = '0;
            step_q = STEP_BACKOFF1_WAIT;
          end
          STEP_BACKOFF1_WAIT: if (elapsed_q >= cfg_q.first_backoff_ms) begin
            slab_q = '0;
            step_q = STEP_PULL_START;
          end
          STEP_PULL_START: begin
            pull_q = drive_level(1'b0);
            step_q = STEP_PULL_WAIT;
          end
          STEP_PULL_WAIT: if (it.limit_switch) begin
            pull_q = '0;
            step_q = STEP_SLAB2_START;
          end
          STEP_SLAB2_START: begin
            slab_q = drive_level(1'b0);
            step_q = STEP_SLAB2_WAIT;
          end
          STEP_SLAB2_WAIT: if (pressed) begin
            slab_q = '0;
            step_q = STEP_BACKOFF2_START;
          end
          STEP_BACKOFF2_START: begin
            slab_q = drive_level(1'b1);
            elapsed_q = '0;
            step_q = STEP_BACKOFF2_WAIT;
          end
          STEP_BACKOFF2_WAIT: if (elapsed_q >= cfg_q.second_backoff_ms) begin
            slab_q = '0;
            elapsed_q = '0;
            step_q = STEP_SETTLE;
          end
          STEP_SETTLE: if (elapsed_q >= cfg_q.settle_ms) begin
            pull_q = drive_level(1'b1);
            elapsed_q = '0;
            step_q = STEP_PULL_CW;
          end
          STEP_PULL_CW: if (elapsed_q >= cfg_q.pull_ms) begin
            pull_q = '0;
            step_q = STEP_SLAB3_START;
          end
          STEP_SLAB3_START: begin
            slab_q = drive_level(1'b0);
            step_q = STEP_SLAB3_WAIT;
          end
          STEP_SLAB3_WAIT: if (pressed) begin
            slab_q = '0;
            step_q = STEP_DONE;
          end
          STEP_DONE: running_q = 1'b0;
          default: ;
        endcase
      end
    end
    res.pull = pull_q;
    res.slab = slab_q;
    res.step_number = step_q;
    res.busy_res = running_q;
    return res;
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("pull a%b b%b duty %0d, slab a%b b%b duty %0d, step %0d, busy %b, reply %0d",
                     r.pull.in_a, r.pull.in_b, r.pull.duty, r.slab.in_a, r.slab.in_b,
                     r.slab.duty, r.step_number, r.busy_res, r.reply);
  endfunction

  // Watch both streams and the register port on every edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t got;
    item_t   it;
    if (!rst_ni) begin
      cfg_q.drive_duty = DRIVE_DUTY_RST;
      cfg_q.first_backoff_ms = FIRST_BACK_RST;
      cfg_q.second_backoff_ms = SECOND_BACK_RST;
      cfg_q.settle_ms = SETTLE_RST;
      cfg_q.pull_ms = PULL_RST;
      clear_sequence();
      motor_state_q.delete();
      mismatch_count_o = 0;
    end else begin
      // Compare a result transaction with the oldest prediction
      if (out_tvalid_i && out_tready_i) begin
        got.pull.in_a = out_tdata_i[0];
        got.pull.in_b = out_tdata_i[1];
        got.pull.duty = out_tdata_i[9:2];
        got.slab.in_a = out_tdata_i[10];
        got.slab.in_b = out_tdata_i[11];
        got.slab.duty = out_tdata_i[19:12];
        got.step_number = step_e'(out_tdata_i[23:20]);
        got.busy_res = out_tdata_i[24];
        got.reply = reply_e'(out_tdata_i[27:25]);
        if (motor_state_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: result with nothing outstanding: %s", $realtime, describe(got));
        end else begin
          want = motor_state_q.pop_front();
          if (got.pull !== want.pull || got.slab !== want.slab ||
              got.step_number !== want.step_number || got.busy_res !== want.busy_res ||
              got.reply !== want.reply) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: motor state mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      // Track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_DRIVE_DUTY:  cfg_q.drive_duty = pwdata_i[7:0];
          REG_FIRST_BACK:  cfg_q.first_backoff_ms = pwdata_i[15:0];
          REG_SECOND_BACK: cfg_q.second_backoff_ms = pwdata_i[15:0];
          REG_SETTLE:      cfg_q.settle_ms = pwdata_i[15:0];
          REG_PULL:        cfg_q.pull_ms = pwdata_i[15:0];
          default: ;
        endcase
      end
      // Predict the result of an accepted command or tick
      if (in_tvalid_i && in_tready_i) begin
        it.func = in_tuser_i;
        it.command = cmd_e'(in_tdata_i[1:0]);
        it.slab_switch = in_tdata_i[2];
        it.limit_switch = in_tdata_i[3];
        motor_state_q.push_back(predict_motors(it));
      end
    end
    pending_o = motor_state_q.size();
  end

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [1:0] command, [2] slab_switch, [3] limit_switch
  logic        s_axis_tuser = 1'b0; // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // see the checker for the field layout
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          results_pending;

  // Commands and ticks waiting to be offered
  item_t       feed_q[$];
  int          items_fed = 0;
  int          squeeze_req_count = 0;

  always #10 clk_i = ~clk_i;

  two_motor_feed_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  feed_sequencer_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_tvalid_i      (s_axis_tvalid),
    .in_tready_i      (s_axis_tready),
    .in_tdata_i       (s_axis_tdata),
    .in_tuser_i       (s_axis_tuser),
    .out_tvalid_i     (m_axis_tvalid),
    .out_tready_i     (m_axis_tready),
    .out_tdata_i      (m_axis_tdata),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatches),
    .pending_o        (results_pending)
  );

  task automatic queue_tick(logic slab_level, logic limit_level);
    item_t it;
    it.func = 1'b0;
    it.command = cmd_e'($urandom_range(0, 3));
    it.slab_switch = slab_level;
    it.limit_switch = limit_level;
    feed_q.push_back(it);
    items_fed++;
  endtask

  task automatic queue_command(cmd_e code);
    item_t it;
    it.func = 1'b1;
    it.command = code;
    it.slab_switch = $urandom_range(0, 1);
    it.limit_switch = $urandom_range(0, 1);
    feed_q.push_back(it);
    items_fed++;
  endtask

  // Tick with the slab switch pressed and the limit reached about a third of the time
  task automatic random_tick();
    queue_tick($urandom_range(0, 99) < 35 ? 1'b0 : 1'b1, $urandom_range(0, 99) < 35);
  endtask

  // Mostly a go then ticks with a rare stray command; now and then random items only
  task automatic feed_run();
    int n;
    n = $urandom_range(20, 80);
    if ($urandom_range(0, 9) == 0) begin
      repeat (n) begin
        if ($urandom_range(0, 1)) queue_command(cmd_e'($urandom_range(0, 3)));
        else random_tick();
      end
    end else begin
      queue_command(CMD_GO);
      repeat (n) begin
        if ($urandom_range(0, 99) < 2) queue_command(cmd_e'($urandom_range(0, 3)));
        else random_tick();
      end
    end
  endtask

  task automatic reg_write(logic [2:0] index, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_regs(logic [7:0] duty, logic [15:0] first_ms, logic [15:0] second_ms,
                              logic [15:0] settle_time, logic [15:0] pull_time);
    reg_write(REG_DRIVE_DUTY, {24'd0, duty});
    reg_write(REG_FIRST_BACK, {16'd0, first_ms});
    reg_write(REG_SECOND_BACK, {16'd0, second_ms});
    reg_write(REG_SETTLE, {16'd0, settle_time});
    reg_write(REG_PULL, {16'd0, pull_time});
  endtask

  function automatic logic [15:0] random_ms();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 8));
  endfunction

  // Wait until everything offered has been accepted and answered
  task automatic wait_idle();
    do @(negedge clk_i);
    while (feed_q.size() != 0 || s_axis_tvalid || results_pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Offer queued transactions in bursts separated by random gaps
  initial begin : sender
    int    burst_left;
    int    gap_left;
    item_t it;
    burst_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (feed_q.size() != 0) begin
          it = feed_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= it.func;
          s_axis_tdata <= {4'd0, it.limit_switch, it.slab_switch, it.command};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Accept results on a changing pattern; hold off for a long stretch on request
  initial begin : receiver
    logic [31:0] pattern;
    int          pattern_age;
    int          bit_idx;
    int          hold_left;
    int          squeezes_done;
    pattern = '1;
    pattern_age = 0;
    bit_idx = 0;
    hold_left = 0;
    squeezes_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (squeezes_done != squeeze_req_count) begin
        squeezes_done++;
        hold_left = 299;
        m_axis_tready <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          pattern_age = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: pattern = '1;
            1: pattern = $urandom;
            2: pattern = $urandom | $urandom;
            default: pattern = $urandom & $urandom;
          endcase
        end
        pattern_age--;
        m_axis_tready <= pattern[bit_idx];
        bit_idx = (bit_idx + 1) % 32;
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int directed_items;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle behavior at the reset register values
    queue_tick(1'b0, 1'b1);
    queue_tick(1'b1, 1'b0);
    queue_command(CMD_INVALID);
    queue_command(CMD_RESET);
    wait_idle();

    // Walk the whole sequence with short step times, pausing once with stop
    program_regs(8'h5A, 16'd0, 16'd1, 16'd2, 16'd1);
    queue_command(CMD_GO);
    queue_tick(1'b1, 1'b0);   // slab counter-clockwise
    queue_tick(1'b1, 1'b1);   // switch not pressed: hold
    queue_tick(1'b0, 1'b0);   // pressed: slab off
    queue_tick(1'b0, 1'b0);   // slab clockwise, counter cleared
    queue_tick(1'b1, 1'b0);   // zero backoff ends on first tick
    queue_tick(1'b1, 1'b0);   // pull counter-clockwise
    queue_tick(1'b0, 1'b0);   // limit not reached: hold
    queue_command(CMD_STOP);  // motors off, step kept
    queue_tick(1'b1, 1'b1);   // limit reached
    queue_tick(1'b1, 1'b1);   // slab counter-clockwise again
    queue_tick(1'b0, 1'b1);   // pressed
    queue_tick(1'b0, 1'b0);   // second backoff
    queue_tick(1'b0, 1'b0);   // backoff of one ends
    queue_tick(1'b1, 1'b0);   // settle not yet over
    queue_tick(1'b1, 1'b0);   // pull clockwise
    queue_tick(1'b1, 1'b0);   // pull time over
    queue_tick(1'b1, 1'b0);   // last slab run
    queue_tick(1'b0, 1'b0);   // pressed
    queue_tick(1'b1, 1'b1);   // sequence done
    wait_idle();
    directed_items = items_fed;

    // Random runs under a series of register settings
    phase = 0;
    while (items_fed - directed_items < 660) begin
      case (phase)
        0: program_regs(8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: program_regs(8'd255, 16'd1, 16'd1, 16'd1, 16'd1);
        default: program_regs(8'($urandom_range(0, 255)), random_ms(), random_ms(),
                              random_ms(), random_ms());
      endcase
      if (phase == 0) squeeze_req_count++;
      repeat ($urandom_range(3, 6)) feed_run();
      wait_idle();
      phase++;
    end

    // Longest step times; the first backoff holds
    program_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_command(CMD_RESET);
    queue_command(CMD_GO);
    queue_tick(1'b1, 1'b0);
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b0);
    repeat (40) random_tick();
    wait_idle();

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/tmfs_pkg.sv
sv/tmfs_regs.sv
sv/tmfs_core.sv
sv/two_motor_feed_sequencer.sv
verif/feed_sequencer_checker.sv
verif/tb.sv
